// ===== hw/rtl/assert_macros.svh =====
// Concurrent check helpers; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PID_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pid controller check failed");

// Consequent checked in the cycle after the antecedent.
`define PID_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pid controller check failed");

`endif

// ===== hw/rtl/pidaw_pkg.sv =====
package pidaw_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int GAIN_W     = DATA_WIDTH - 1;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int QW         = PROD_W - FRAC_BITS;

  localparam logic [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DDERIV_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDUP_LIM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_RECIP  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_MODE   = 3'd7;

  localparam logic [GAIN_W-1:0] STEP_TIME_RST  = GAIN_W'(655);
  localparam logic [GAIN_W-1:0] STEP_RECIP_RST = GAIN_W'(6553600);

  // Input word action codes
  localparam logic [1:0] ACT_COMPUTE = 2'd0;
  localparam logic [1:0] ACT_CLEAR   = 2'd1;
  localparam logic [1:0] ACT_FORCE   = 2'd2;

  // Value plus saturation flag from the shared arithmetic
  typedef struct packed {
    logic [DATA_WIDTH-1:0] val;
    logic                  ovf;
  } arith_res_t;

  // Saturating a + b, or a + (-b) with a saturating negation of b
  function automatic arith_res_t sat_add(input logic [DATA_WIDTH-1:0] a,
                                         input logic [DATA_WIDTH-1:0] b,
                                         input logic neg_b);
    arith_res_t            res;
    logic [DATA_WIDTH-1:0] nb;
    logic                  neg_ovf;
    logic [DATA_WIDTH:0]   s;
    logic                  add_ovf;
    neg_ovf = neg_b && (b == DMIN);
    if (!neg_b) begin
      nb = b;
    end else if (neg_ovf) begin
      nb = DMAX;
    end else begin
      nb = (~b) + DATA_WIDTH'(1);
    end
    s = {a[DATA_WIDTH-1], a} + {nb[DATA_WIDTH-1], nb};
    add_ovf = s[DATA_WIDTH] != s[DATA_WIDTH-1];
    if (add_ovf) begin
      res.val = s[DATA_WIDTH] ? DMIN : DMAX;
    end else begin
      res.val = s[DATA_WIDTH-1:0];
    end
    res.ovf = add_ovf || neg_ovf;
    return res;
  endfunction

endpackage

// ===== hw/rtl/pid_controller_anti_windup.sv =====
// Positional PID controller with anti-windup, signed Q16.16. One
// fixed-point multiplier (product registered, then normalized) and one
// saturating adder are shared by all terms under a sequencer, so the
// sequence grows with the enabled terms: integral steps with a nonzero
// integral gain that may grow, derivative steps with a derivative gain
// (fewer in rate mode than in error-difference mode) and second-
// derivative steps with a second-derivative gain. Clear and force words
// return no result. in_stall is high while a word is in progress; a
// finished result waits in the output register while the next word runs.
`include "assert_macros.svh"

module pid_controller_anti_windup (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_action,
  input  logic signed [pidaw_pkg::DATA_WIDTH-1:0] in_error_in,
  input  logic signed [pidaw_pkg::DATA_WIDTH-1:0] in_rate_in,
  input  logic signed [pidaw_pkg::DATA_WIDTH-1:0] in_accel_in,
  input  logic signed [pidaw_pkg::DATA_WIDTH-1:0] in_forced_integral,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [pidaw_pkg::DATA_WIDTH-1:0] out_command,
  output logic                                 out_saturated,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pidaw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pidaw_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int DW = pidaw_pkg::DATA_WIDTH;
  localparam int GW = pidaw_pkg::GAIN_W;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL_P,  ST_NRM_P,
    ST_MUL_I1, ST_NRM_I1, ST_MUL_I2, ST_NRM_I2, ST_ACC_I,
    ST_ADD_I,
    ST_DIF_D,  ST_MUL_D,  ST_NRM_D,  ST_MUL_D2, ST_NRM_D2, ST_ADD_D,
    ST_NEG_A,  ST_MUL_A,  ST_NRM_A,  ST_ADD_A,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;

  logic [GW-1:0] kp_r, kp_nxt, ki_r, ki_nxt, kd_r, kd_nxt, kdd_r, kdd_nxt;
  logic [GW-1:0] lim_r, lim_nxt, dt_r, dt_nxt, recip_r, recip_nxt;
  logic          rate_mode_r, rate_mode_nxt;

  logic [DW-1:0] err_r, err_nxt, rate_r, rate_nxt, accel_r, accel_nxt;
  logic [DW-1:0] u_r, u_nxt, tmp_r, tmp_nxt;
  logic [DW-1:0] integ_r, integ_nxt, last_err_r, last_err_nxt;
  logic          sat_r, sat_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [DW-1:0] out_command_r, out_command_nxt;
  logic          out_saturated_r, out_saturated_nxt;

  logic [DW-1:0]         mul_a, mul_b;
  pidaw_pkg::arith_res_t mul_res;
  logic [DW-1:0]         add_a, add_b;
  logic                  add_neg_b;
  pidaw_pkg::arith_res_t add_res;

  logic signed [DW:0] integ_x, lim_x;
  logic               at_limit, grow, int_step;
  logic               in_take, out_free;

  pidaw_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .res (mul_res)
  );

  assign add_res = pidaw_pkg::sat_add(add_a, add_b, add_neg_b);

  // Anti-windup: at or past the limit, only accumulate against the sign
  assign integ_x  = {integ_r[DW-1], integ_r};
  assign lim_x    = (DW+1)'(lim_r);
  assign at_limit = (lim_r != '0) && !((integ_x > -lim_x) && (integ_x < lim_x));
  assign grow     = !at_limit ||
                    (($signed(integ_r) > 0) && ($signed(err_r) < 0)) ||
                    (($signed(integ_r) < 0) && ($signed(err_r) > 0));
  assign int_step = (ki_r != '0) && grow;

  assign in_stall  = state_r != ST_IDLE;
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  assign out_valid     = out_valid_r;
  assign out_command   = out_command_r;
  assign out_saturated = out_saturated_r;

  // Operand selection for the shared multiplier and adder
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    add_a     = '0;
    add_b     = '0;
    add_neg_b = 1'b0;
    unique case (state_r)
      ST_MUL_P: begin
        mul_a = err_r;
        mul_b = DW'(kp_r);
      end
      ST_MUL_I1: begin
        mul_a = DW'(ki_r);
        mul_b = err_r;
      end
      ST_MUL_I2: begin
        mul_a = tmp_r;
        mul_b = DW'(dt_r);
      end
      ST_MUL_D: begin
        mul_a = DW'(kd_r);
        mul_b = rate_mode_r ? rate_r : tmp_r;
      end
      ST_MUL_D2: begin
        mul_a = tmp_r;
        mul_b = DW'(recip_r);
      end
      ST_MUL_A: begin
        mul_a = DW'(kdd_r);
        mul_b = tmp_r;
      end
      ST_ACC_I: begin
        add_a = integ_r;
        add_b = tmp_r;
      end
      ST_ADD_I: begin
        add_a = u_r;
        add_b = integ_r;
      end
      ST_DIF_D: begin
        add_a     = err_r;
        add_b     = last_err_r;
        add_neg_b = 1'b1;
      end
      ST_NEG_A: begin
        add_b     = accel_r;
        add_neg_b = 1'b1;
      end
      ST_ADD_D, ST_ADD_A: begin
        add_a = u_r;
        add_b = tmp_r;
      end
      default: ;
    endcase
  end

  // Sequencer and datapath next-state
  always_comb begin
    state_nxt         = state_r;
    kp_nxt            = kp_r;
    ki_nxt            = ki_r;
    kd_nxt            = kd_r;
    kdd_nxt           = kdd_r;
    lim_nxt           = lim_r;
    dt_nxt            = dt_r;
    recip_nxt         = recip_r;
    rate_mode_nxt     = rate_mode_r;
    err_nxt           = err_r;
    rate_nxt          = rate_r;
    accel_nxt         = accel_r;
    u_nxt             = u_r;
    tmp_nxt           = tmp_r;
    integ_nxt         = integ_r;
    last_err_nxt      = last_err_r;
    sat_nxt           = sat_r;
    out_command_nxt   = out_command_r;
    out_saturated_nxt = out_saturated_r;
    out_valid_nxt     = out_valid_r && out_stall;

    if (cfg_valid) begin
      unique case (cfg_index)
        pidaw_pkg::CFG_PROP_GAIN:   kp_nxt        = cfg_data[GW-1:0];
        pidaw_pkg::CFG_INT_GAIN:    ki_nxt        = cfg_data[GW-1:0];
        pidaw_pkg::CFG_DERIV_GAIN:  kd_nxt        = cfg_data[GW-1:0];
        pidaw_pkg::CFG_DDERIV_GAIN: kdd_nxt       = cfg_data[GW-1:0];
        pidaw_pkg::CFG_WINDUP_LIM:  lim_nxt       = cfg_data[GW-1:0];
        pidaw_pkg::CFG_STEP_TIME:   dt_nxt        = cfg_data[GW-1:0];
        pidaw_pkg::CFG_STEP_RECIP:  recip_nxt     = cfg_data[GW-1:0];
        pidaw_pkg::CFG_RATE_MODE:   rate_mode_nxt = cfg_data[0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          case (in_action)
            pidaw_pkg::ACT_COMPUTE: begin
              err_nxt   = in_error_in;
              rate_nxt  = in_rate_in;
              accel_nxt = in_accel_in;
              sat_nxt   = 1'b0;
              state_nxt = ST_MUL_P;
            end
            pidaw_pkg::ACT_CLEAR: integ_nxt = '0;
            pidaw_pkg::ACT_FORCE: integ_nxt = in_forced_integral;
            default: ;
          endcase
        end
      end
      ST_MUL_P:  state_nxt = ST_NRM_P;
      ST_NRM_P: begin
        u_nxt     = mul_res.val;
        sat_nxt   = sat_r | mul_res.ovf;
        state_nxt = int_step ? ST_MUL_I1 : ST_ADD_I;
      end
      ST_MUL_I1: state_nxt = ST_NRM_I1;
      ST_NRM_I1: begin
        tmp_nxt   = mul_res.val;
        sat_nxt   = sat_r | mul_res.ovf;
        state_nxt = ST_MUL_I2;
      end
      ST_MUL_I2: state_nxt = ST_NRM_I2;
      ST_NRM_I2: begin
        tmp_nxt   = mul_res.val;
        sat_nxt   = sat_r | mul_res.ovf;
        state_nxt = ST_ACC_I;
      end
      ST_ACC_I: begin
        integ_nxt = add_res.val;
        sat_nxt   = sat_r | add_res.ovf;
        state_nxt = ST_ADD_I;
      end
      ST_ADD_I: begin
        u_nxt   = add_res.val;
        sat_nxt = sat_r | add_res.ovf;
        if (kd_r != '0) begin
          state_nxt = rate_mode_r ? ST_MUL_D : ST_DIF_D;
        end else if (kdd_r != '0) begin
          state_nxt = ST_NEG_A;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_DIF_D: begin
        tmp_nxt   = add_res.val;
        sat_nxt   = sat_r | add_res.ovf;
        state_nxt = ST_MUL_D;
      end
      ST_MUL_D:  state_nxt = ST_NRM_D;
      ST_NRM_D: begin
        tmp_nxt   = mul_res.val;
        sat_nxt   = sat_r | mul_res.ovf;
        state_nxt = rate_mode_r ? ST_ADD_D : ST_MUL_D2;
      end
      ST_MUL_D2: state_nxt = ST_NRM_D2;
      ST_NRM_D2: begin
        tmp_nxt   = mul_res.val;
        sat_nxt   = sat_r | mul_res.ovf;
        state_nxt = ST_ADD_D;
      end
      ST_ADD_D: begin
        u_nxt     = add_res.val;
        sat_nxt   = sat_r | add_res.ovf;
        state_nxt = (kdd_r != '0) ? ST_NEG_A : ST_FIN;
      end
      ST_NEG_A: begin
        tmp_nxt   = add_res.val;
        sat_nxt   = sat_r | add_res.ovf;
        state_nxt = ST_MUL_A;
      end
      ST_MUL_A:  state_nxt = ST_NRM_A;
      ST_NRM_A: begin
        tmp_nxt   = mul_res.val;
        sat_nxt   = sat_r | mul_res.ovf;
        state_nxt = ST_ADD_A;
      end
      ST_ADD_A: begin
        u_nxt     = add_res.val;
        sat_nxt   = sat_r | add_res.ovf;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register is free
        if (out_free) begin
          out_command_nxt   = u_r;
          out_saturated_nxt = sat_r;
          out_valid_nxt     = 1'b1;
          last_err_nxt      = err_r;
          state_nxt         = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    err_r           <= err_nxt;
    rate_r          <= rate_nxt;
    accel_r         <= accel_nxt;
    u_r             <= u_nxt;
    tmp_r           <= tmp_nxt;
    sat_r           <= sat_nxt;
    out_command_r   <= out_command_nxt;
    out_saturated_r <= out_saturated_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      last_err_r  <= '0;
      kp_r        <= '0;
      ki_r        <= '0;
      kd_r        <= '0;
      kdd_r       <= '0;
      lim_r       <= '0;
      dt_r        <= pidaw_pkg::STEP_TIME_RST;
      recip_r     <= pidaw_pkg::STEP_RECIP_RST;
      rate_mode_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      integ_r     <= integ_nxt;
      last_err_r  <= last_err_nxt;
      kp_r        <= kp_nxt;
      ki_r        <= ki_nxt;
      kd_r        <= kd_nxt;
      kdd_r       <= kdd_nxt;
      lim_r       <= lim_nxt;
      dt_r        <= dt_nxt;
      recip_r     <= recip_nxt;
      rate_mode_r <= rate_mode_nxt;
    end
  end

  `PID_ASSERT_NEXT(a_compute_starts, in_take && (in_action == pidaw_pkg::ACT_COMPUTE),
                   state_r == ST_MUL_P)
  `PID_ASSERT_NEXT(a_clear_zeroes, in_take && (in_action == pidaw_pkg::ACT_CLEAR),
                   integ_r == '0)
  `PID_ASSERT_NEXT(a_integ_only_in_acc, (state_r != ST_IDLE) && (state_r != ST_ACC_I),
                   $stable(integ_r))
  `PID_ASSERT_NEXT(a_fin_delivers, (state_r == ST_FIN) && out_free,
                   out_valid && (state_r == ST_IDLE))

endmodule

// ===== hw/rtl/pidaw_mul.sv =====
// Fixed-point multiply: magnitude product registered, then shift by the
// fraction bits, truncate toward zero and saturate on the output side.
module pidaw_mul (
  input  logic                             clk,
  input  logic [pidaw_pkg::DATA_WIDTH-1:0] a,
  input  logic [pidaw_pkg::DATA_WIDTH-1:0] b,
  output pidaw_pkg::arith_res_t            res
);

  localparam int DW = pidaw_pkg::DATA_WIDTH;

  logic [DW-1:0]                 mag_a;
  logic [DW-1:0]                 mag_b;
  logic [pidaw_pkg::PROD_W-1:0]  prod_r;
  logic                          neg_r;
  logic [pidaw_pkg::QW-1:0]      q;
  logic [pidaw_pkg::QW-1:0]      limit;
  logic [DW-1:0]                 q_lo;

  assign mag_a = a[DW-1] ? (~a) + DW'(1) : a;
  assign mag_b = b[DW-1] ? (~b) + DW'(1) : b;

  always_ff @(posedge clk) begin
    prod_r <= pidaw_pkg::PROD_W'(mag_a) * pidaw_pkg::PROD_W'(mag_b);
    neg_r  <= a[DW-1] ^ b[DW-1];
  end

  assign q     = prod_r[pidaw_pkg::PROD_W-1:pidaw_pkg::FRAC_BITS];
  assign limit = (pidaw_pkg::QW'(1) << (DW - 1)) - (neg_r ? '0 : pidaw_pkg::QW'(1));
  assign q_lo  = q[DW-1:0];

  always_comb begin
    res.ovf = q > limit;
    if (res.ovf) begin
      res.val = neg_r ? pidaw_pkg::DMIN : pidaw_pkg::DMAX;
    end else if (neg_r) begin
      res.val = (~q_lo) + DW'(1);
    end else begin
      res.val = q_lo;
    end
  end

endmodule

// ===== test/pid_controller_anti_windup_test.sv =====
module pid_controller_anti_windup_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pidaw_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam logic [CFG_DATA_W-1:0] GAIN_MAX = 32'h7FFF_FFFF;
  localparam int NUM_ROWS = 33;
  localparam int NUM_PHASES = 10;
  localparam int WORDS_PER_PHASE = 163;
  localparam int SETTLE_CYCLES = 25;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] cmd;
    logic                  sat;
  } cmd_word_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [1:0]            act;
    logic [DATA_WIDTH-1:0] err;
    logic [DATA_WIDTH-1:0] rate;
    logic [DATA_WIDTH-1:0] accel;
    logic [DATA_WIDTH-1:0] forced;
    logic                  typed;
    cmd_word_t             want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_action;
  logic signed [DATA_WIDTH-1:0] in_error_in;
  logic signed [DATA_WIDTH-1:0] in_rate_in;
  logic signed [DATA_WIDTH-1:0] in_accel_in;
  logic signed [DATA_WIDTH-1:0] in_forced_integral;
  logic out_valid;
  logic out_stall;
  logic signed [DATA_WIDTH-1:0] out_command;
  logic out_saturated;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Controller image: gains, timing and the two state words
  longint kp = 0;
  longint ki = 0;
  longint kd = 0;
  longint kdd = 0;
  longint lim = 0;
  longint dt = longint'(STEP_TIME_RST);
  longint recip = longint'(STEP_RECIP_RST);
  bit rate_sel = 1'b0;
  longint integ = 0;
  longint last_err = 0;
  bit step_ovf;

  cmd_word_t pending_cmds[$];
  int mismatches = 0;
  bit use_typed = 1'b0;
  cmd_word_t typed_want = '0;
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int hold_requests = 0;
  int holds_done = 0;
  int hold_left = 0;

  pid_controller_anti_windup DUT (.*);

  always #5ns clk = ~clk;

  // Product shifted down by the fraction bits, truncated toward zero
  function automatic longint mul_q(longint a, longint b);
    bit neg;
    longint q;
    neg = (a < 0) != (b < 0);
    q = ((a < 0 ? -a : a) * (b < 0 ? -b : b)) >>> FRAC_BITS;
    if (!neg && q > Q_MAX) begin
      step_ovf = 1'b1;
      return Q_MAX;
    end
    if (neg && q > Q_MAX + 1) begin
      step_ovf = 1'b1;
      return Q_MIN;
    end
    return neg ? -q : q;
  endfunction

  function automatic longint sum_sat(longint a, longint b);
    longint s;
    s = a + b;
    if (s > Q_MAX) begin
      step_ovf = 1'b1;
      return Q_MAX;
    end
    if (s < Q_MIN) begin
      step_ovf = 1'b1;
      return Q_MIN;
    end
    return s;
  endfunction

  function automatic longint neg_sat(longint a);
    if (a == Q_MIN) begin
      step_ovf = 1'b1;
      return Q_MAX;
    end
    return -a;
  endfunction

  function automatic cmd_word_t pid_step(longint e, longint rate, longint accel);
    cmd_word_t r;
    longint u;
    bit grow;
    step_ovf = 1'b0;
    u = mul_q(e, kp);
    if (ki != 0) begin
      grow = 1'b1;
      // at or past the limit: only unwind
      if (lim != 0 && !(integ > -lim && integ < lim))
        grow = (integ > 0 && e < 0) || (integ < 0 && e > 0);
      if (grow)
        integ = sum_sat(integ, mul_q(mul_q(ki, e), dt));
    end
    u = sum_sat(u, integ);
    if (kd != 0) begin
      if (rate_sel)
        u = sum_sat(u, mul_q(kd, rate));
      else
        u = sum_sat(u, mul_q(mul_q(kd, sum_sat(e, neg_sat(last_err))), recip));
    end
    if (kdd != 0)
      u = sum_sat(u, mul_q(kdd, neg_sat(accel)));
    last_err = e;
    r.cmd = u[DATA_WIDTH-1:0];
    r.sat = step_ovf;
    return r;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10)
      $display("%s", msg);
  endfunction

  always @(posedge clk) begin : word_monitor
    cmd_word_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PROP_GAIN:   kp = longint'(cfg_data[GAIN_W-1:0]);
          CFG_INT_GAIN:    ki = longint'(cfg_data[GAIN_W-1:0]);
          CFG_DERIV_GAIN:  kd = longint'(cfg_data[GAIN_W-1:0]);
          CFG_DDERIV_GAIN: kdd = longint'(cfg_data[GAIN_W-1:0]);
          CFG_WINDUP_LIM:  lim = longint'(cfg_data[GAIN_W-1:0]);
          CFG_STEP_TIME:   dt = longint'(cfg_data[GAIN_W-1:0]);
          CFG_STEP_RECIP:  recip = longint'(cfg_data[GAIN_W-1:0]);
          CFG_RATE_MODE:   rate_sel = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (in_action)
          ACT_COMPUTE: begin
            want = pid_step(longint'(in_error_in), longint'(in_rate_in),
                            longint'(in_accel_in));
            pending_cmds.push_back(use_typed ? typed_want : want);
          end
          ACT_CLEAR: integ = 0;
          ACT_FORCE: integ = longint'(in_forced_integral);
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pending_cmds.size() == 0) begin
          note_mismatch($sformatf("unexpected word: command %h saturated %b",
                                  out_command, out_saturated));
        end else begin
          want = pending_cmds.pop_front();
          if (out_command !== want.cmd)
            note_mismatch($sformatf("command: expected %h got %h", want.cmd, out_command));
          if (out_saturated !== want.sat)
            note_mismatch($sformatf("saturated: expected %b got %b (command %h)",
                                    want.sat, out_saturated, out_command));
        end
      end
    end
  end

  // Receiver: random stall, or a counted hold-off when one is requested
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (holds_done != hold_requests) begin
        holds_done++;
        hold_left = HOLD_CYCLES - 1;
        out_stall = 1'b1;
      end else begin
        out_stall = ($urandom_range(99) < out_stall_pct);
      end
    end
  end

  initial begin
    #10ms;
    $display("pid_controller_anti_windup_test NOT OK");
    $finish;
  end

  function automatic logic [DATA_WIDTH-1:0] rand_q();
    case ($urandom_range(9))
      0: return DMAX;
      1: return DMIN;
      2: return '0;
      3, 4, 5: return $urandom();
      default: return 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_gain();
    case ($urandom_range(7))
      0: return '0;
      1: return GAIN_MAX;
      2: return $urandom();
      default: return $urandom_range(0, 32'h30000);
    endcase
  endfunction

  function automatic stim_row_t item_row(logic [1:0] act, logic [31:0] e, logic [31:0] r,
                                         logic [31:0] a, logic [31:0] f);
    stim_row_t row;
    row = '0;
    row.act = act;
    row.err = e;
    row.rate = r;
    row.accel = a;
    row.forced = f;
    return row;
  endfunction

  function automatic stim_row_t typed_row(logic [1:0] act, logic [31:0] e, logic [31:0] r,
                                          logic [31:0] a, logic [31:0] cmd, logic sat);
    stim_row_t row;
    row = item_row(act, e, r, a, '0);
    row.typed = 1'b1;
    row.want.cmd = cmd;
    row.want.sat = sat;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = data;
    return row;
  endfunction

  task automatic send_word(logic [1:0] act, logic [31:0] e, logic [31:0] r, logic [31:0] a,
                           logic [31:0] f, logic typed, cmd_word_t want);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_action = act;
    in_error_in = e;
    in_rate_in = r;
    in_accel_in = a;
    in_forced_integral = f;
    use_typed = typed;
    typed_want = want;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid, let every expected word arrive, then let the block settle
  task automatic wait_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_setting(logic [31:0] p, logic [31:0] i, logic [31:0] d,
                               logic [31:0] dd, logic [31:0] wl, logic [31:0] st,
                               logic [31:0] sr, logic [31:0] rm);
    cfg_write(CFG_PROP_GAIN, p);
    cfg_write(CFG_INT_GAIN, i);
    cfg_write(CFG_DERIV_GAIN, d);
    cfg_write(CFG_DDERIV_GAIN, dd);
    cfg_write(CFG_WINDUP_LIM, wl);
    cfg_write(CFG_STEP_TIME, st);
    cfg_write(CFG_STEP_RECIP, sr);
    cfg_write(CFG_RATE_MODE, rm);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin in_idle_pct = 0; out_stall_pct = 0; end
      1: begin in_idle_pct = 47; out_stall_pct = 0; end
      2: begin in_idle_pct = 0; out_stall_pct = 47; end
      default: begin in_idle_pct = 23; out_stall_pct = 23; end
    endcase
  endtask

  initial begin
    stim_row_t rows [NUM_ROWS];
    logic [1:0] act;
    logic [CFG_DATA_W-1:0] dt_v;
    logic [CFG_DATA_W-1:0] recip_v;
    int sent;
    int pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_COMPUTE;
    in_error_in = '0;
    in_rate_in = '0;
    in_accel_in = '0;
    in_forced_integral = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_PROP_GAIN;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    rows = '{
      // all gains zero after reset: command is the integrator alone
      typed_row(ACT_COMPUTE, DMAX, DMAX, DMIN, '0, 1'b0),
      typed_row(ACT_COMPUTE, DMIN, DMIN, DMAX, '0, 1'b0),
      item_row(ACT_FORCE, '0, '0, '0, DMAX),
      typed_row(ACT_COMPUTE, '0, '0, '0, DMAX, 1'b0),
      item_row(ACT_FORCE, '0, '0, '0, DMIN),
      typed_row(ACT_COMPUTE, 32'h1234_5678, '0, '0, DMIN, 1'b0),
      item_row(ACT_UNUSED, DMAX, DMAX, DMAX, 32'h0000_0005),
      typed_row(ACT_COMPUTE, '0, '0, '0, DMIN, 1'b0),
      item_row(ACT_CLEAR, DMIN, '0, '0, '0),
      typed_row(ACT_COMPUTE, DMAX, '0, '0, '0, 1'b0),
      cfg_row(CFG_PROP_GAIN, 32'h0001_0000),
      typed_row(ACT_COMPUTE, DMAX, '0, '0, DMAX, 1'b0),
      typed_row(ACT_COMPUTE, DMIN, '0, '0, DMIN, 1'b0),
      // bit 31 of the write is dropped, leaving the largest gain
      cfg_row(CFG_PROP_GAIN, 32'hFFFF_FFFF),
      typed_row(ACT_COMPUTE, DMAX, '0, '0, DMAX, 1'b1),
      typed_row(ACT_COMPUTE, DMIN, '0, '0, DMIN, 1'b1),
      typed_row(ACT_COMPUTE, '0, '0, '0, '0, 1'b0),
      cfg_row(CFG_PROP_GAIN, 32'h0000_8000),
      cfg_row(CFG_INT_GAIN, 32'h0001_0000),
      cfg_row(CFG_WINDUP_LIM, 32'h0001_0000),
      cfg_row(CFG_STEP_TIME, 32'h0001_0000),
      // integrator reaches the limit, is held, then unwinds
      item_row(ACT_COMPUTE, 32'h0002_0000, '0, '0, '0),
      item_row(ACT_COMPUTE, 32'h0002_0000, '0, '0, '0),
      item_row(ACT_COMPUTE, 32'hFFFF_0000, '0, '0, '0),
      cfg_row(CFG_DERIV_GAIN, 32'h0001_0000),
      cfg_row(CFG_STEP_RECIP, GAIN_MAX),
      item_row(ACT_COMPUTE, DMAX, '0, '0, '0),
      item_row(ACT_COMPUTE, DMIN, '0, '0, '0),
      cfg_row(CFG_RATE_MODE, 32'h0000_0001),
      item_row(ACT_COMPUTE, '0, DMIN, '0, '0),
      cfg_row(CFG_DDERIV_GAIN, 32'h0001_0000),
      item_row(ACT_COMPUTE, '0, '0, DMIN, '0),
      item_row(ACT_COMPUTE, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, '0)
    };

    set_idling(3);
    foreach (rows[n]) begin
      if (rows[n].is_cfg) begin
        wait_drain();
        cfg_write(rows[n].idx, rows[n].data);
      end else begin
        send_word(rows[n].act, rows[n].err, rows[n].rate, rows[n].accel, rows[n].forced,
                  rows[n].typed, rows[n].want);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drain();
      if (p == 0) begin
        write_setting(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX,
                      32'h1);
      end else if (p == 1) begin
        write_setting('0, '0, '0, '0, '0, 32'h1, 32'h1, '0);
      end else begin
        do dt_v = rand_gain(); while (dt_v[GAIN_W-1:0] == '0);
        do recip_v = rand_gain(); while (recip_v[GAIN_W-1:0] == '0);
        write_setting(rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                      dt_v, recip_v, $urandom());
      end
      set_idling(p % 4);
      sent = 0;
      while (sent < WORDS_PER_PHASE) begin
        pick = $urandom_range(99);
        act = pick < 86 ? ACT_COMPUTE : pick < 91 ? ACT_CLEAR :
              pick < 96 ? ACT_FORCE : ACT_UNUSED;
        send_word(act, rand_q(), rand_q(), rand_q(), rand_q(), 1'b0, '0);
        if (act != ACT_UNUSED) begin
          sent++;
          // long receiver hold-off while words keep coming
          if (p == 4 && sent == 40)
            hold_requests++;
          if (p == 6 && sent == 80)
            wait_drain();
        end
      end
    end
    wait_drain();

    if (mismatches == 0 && pending_cmds.size() == 0)
      $display("pid_controller_anti_windup_test OK");
    else
      $display("pid_controller_anti_windup_test NOT OK");
    $finish;
  end

endmodule
